### hw/rtl/tmbt_pkg.sv
// ----------------------------------------------------------------------------
// Tiny MLP trainer package
// Shared widths, types, action codes and fixed-point helper functions.
// ----------------------------------------------------------------------------
package tmbt_pkg;

  localparam int H        = 3;
  localparam int F        = 16;
  localparam int NW       = H * (H + 2);
  localparam int OUT_BASE = H + H * H;
  localparam int ACCW     = 48;
  localparam int SUMW     = 52;
  localparam int ESW      = 47;
  localparam int MOPW     = 33;
  localparam int PRODW    = 2 * MOPW;

  typedef logic signed [31:0]       q_t;
  typedef logic signed [ACCW-1:0]   acc_t;
  typedef logic signed [SUMW-1:0]   sum_t;
  typedef logic signed [MOPW-1:0]   mop_t;
  typedef logic signed [PRODW-1:0]  prod_t;
  typedef logic [3:0]               widx_t;
  typedef logic [1:0]               act_t;

  localparam act_t ACT_TRAIN  = 2'd0;
  localparam act_t ACT_EVAL   = 2'd1;
  localparam act_t ACT_UPDATE = 2'd2;
  localparam act_t ACT_LOAD   = 2'd3;

  localparam logic CFG_RATE = 1'b0;
  localparam logic CFG_BIAS = 1'b1;

  // Multiplier request from the sequencer to the shared unit.
  typedef struct packed {
    logic en;
    mop_t a;
    mop_t b;
  } mul_req_t;

  // Clamp a wide sum to signed 32 bits.
  function automatic q_t sat32(input sum_t v);
    if (v > sum_t'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (v < -sum_t'(33'sh080000000)) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // Saturating add of a product term to a gradient sum.
  function automatic acc_t acc_add(input acc_t a, input sum_t p);
    sum_t s;
    sum_t amax;
    s    = sum_t'(a) + p;
    amax = sum_t'({1'b0, {(ACCW-1){1'b1}}});
    if (s > amax) begin
      return {1'b0, {(ACCW-1){1'b1}}};
    end else if (s < -amax - sum_t'(1)) begin
      return {1'b1, {(ACCW-1){1'b0}}};
    end else begin
      return s[ACCW-1:0];
    end
  endfunction

  // Flat index of hidden weight (k, j).
  function automatic widx_t hid_idx(input logic [1:0] k, input logic [1:0] j);
    return widx_t'(H + H * int'(k) + int'(j));
  endfunction

endpackage

### hw/rtl/tiny_mlp_batch_backprop_trainer_top.sv
// ----------------------------------------------------------------------------
// Tiny MLP batch backprop trainer
// Linear 1-3-3-1 network trained by batch gradient descent in Q16.16.
// ----------------------------------------------------------------------------
// One item is in work at a time, from accept through the result; a result can wait
// while out_stall holds the result register. The next item can be accepted in the
// cycle that the result appears. The shared multiplier sets the pace: each product
// is registered in the multiplier before it is used. Synchronous active-low reset
// clears weights, sums and the error total, and loads the rate and bias registers
// with their reset values.
module tiny_mlp_batch_backprop_trainer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tmbt_pkg::act_t       in_action,
  input  tmbt_pkg::q_t         in_sample_x,
  input  tmbt_pkg::q_t         in_sample_y,
  input  tmbt_pkg::widx_t      in_weight_index,
  input  tmbt_pkg::q_t         in_weight_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tmbt_pkg::q_t         out_prediction,
  output tmbt_pkg::q_t         out_error,
  output logic [46:0]          out_error_sum
);
  import tmbt_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_BIAS  = 11'b00000000010,
    S_L1    = 11'b00000000100,
    S_L2    = 11'b00000001000,
    S_L3    = 11'b00000010000,
    S_EVAL  = 11'b00000100000,
    S_OUTG  = 11'b00001000000,
    S_HID   = 11'b00010000000,
    S_FIRST = 11'b00100000000,
    S_UPD   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  localparam logic [ESW-1:0] ERR_MAX = {ESW{1'b1}};
  localparam logic [49:0]    STEP_CLAMP = 50'h2_0000_0000;

  state_t          state_r, state_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic [1:0]      k_r, k_nxt, j_r, j_nxt;
  logic [3:0]      ui_r, ui_nxt;
  act_t            act_r, act_nxt;
  q_t              x_r, x_nxt, y_r, y_nxt;
  acc_t            b_r, b_nxt;
  sum_t            acc_r, acc_nxt;
  q_t              d1_r, d1_nxt, pred_r, pred_nxt, err_r, err_nxt;
  logic [63:0]     lo_r, lo_nxt;
  logic [ESW-1:0]  sqerr_r, sqerr_nxt;
  logic [31:0]     rate_r;
  q_t              bias_r;
  logic            out_valid_r, out_valid_nxt;
  q_t              out_pred_r, out_pred_nxt, out_err_r, out_err_nxt;
  logic [ESW-1:0]  out_es_r, out_es_nxt;

  q_t   w_r [NW];
  acc_t g_r [NW];
  q_t   z1_r [H];
  q_t   z2_r [H];
  q_t   d2_r [H];

  logic  w_we, g_we, z1_we, z2_we, d2_we;
  widx_t w_wa;
  q_t    w_wd, z_wd;
  acc_t  g_wd;

  widx_t    idx;
  q_t       w_rd;
  acc_t     g_rd;
  logic [ACCW-1:0] g_mag;
  mul_req_t mreq;
  prod_t    prod;
  prod_t    prod_shr;
  sum_t     sh;

  // Temporaries for the step logic.
  sum_t        s;
  q_t          p;
  logic [47:0] es_sum;
  logic [49:0] q50;
  logic [33:0] q34;
  logic signed [35:0] step, wdiff;

  tmbt_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  assign prod_shr = prod >>> F;
  assign sh       = prod_shr[SUMW-1:0];

  // Weight and gradient address for the current step.
  always_comb begin
    unique case (state_r)
      S_L1, S_FIRST: idx = widx_t'(k_r);
      S_L2, S_HID:   idx = hid_idx(k_r, j_r);
      S_L3, S_OUTG:  idx = widx_t'(OUT_BASE + int'(j_r));
      S_UPD:         idx = ui_r;
      default:       idx = '0;
    endcase
  end

  assign w_rd  = w_r[idx];
  assign g_rd  = g_r[idx];
  assign g_mag = g_rd[ACCW-1] ? (-g_rd) : g_rd;

  // Operand selection for the shared multiplier.
  always_comb begin
    mreq.en = (state_r != S_IDLE) && (state_r != S_DONE);
    mreq.a  = '0;
    mreq.b  = '0;
    unique case (state_r)
      S_BIAS: begin
        mreq.a = mop_t'(bias_r);
        mreq.b = mop_t'(bias_r);
      end
      S_L1: begin
        mreq.a = mop_t'(w_rd);
        mreq.b = mop_t'(x_r);
      end
      S_L2: begin
        mreq.a = mop_t'(w_rd);
        mreq.b = mop_t'(z1_r[k_r]);
      end
      S_L3: begin
        mreq.a = mop_t'(w_rd);
        mreq.b = mop_t'(z2_r[j_r]);
      end
      S_EVAL: begin
        mreq.a = mop_t'(err_r);
        mreq.b = mop_t'(err_r);
      end
      S_OUTG: begin
        mreq.a = (ph_r == 2'd0) ? mop_t'(z2_r[j_r]) : mop_t'(w_rd);
        mreq.b = mop_t'(err_r);
      end
      S_HID: begin
        mreq.a = (ph_r == 2'd0) ? mop_t'(z1_r[k_r]) : mop_t'(w_rd);
        mreq.b = mop_t'(d2_r[j_r]);
      end
      S_FIRST: begin
        mreq.a = mop_t'(x_r);
        mreq.b = mop_t'(d1_r);
      end
      S_UPD: begin
        mreq.a = (ph_r == 2'd0) ? mop_t'({1'b0, g_mag[31:0]})
                                : mop_t'({17'b0, g_mag[47:32]});
        mreq.b = mop_t'({1'b0, rate_r});
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  // Sequencer and datapath step logic.
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    ui_nxt        = ui_r;
    act_nxt       = act_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    d1_nxt        = d1_r;
    pred_nxt      = pred_r;
    err_nxt       = err_r;
    lo_nxt        = lo_r;
    sqerr_nxt     = sqerr_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_pred_nxt  = out_pred_r;
    out_err_nxt   = out_err_r;
    out_es_nxt    = out_es_r;
    w_we  = 1'b0;
    w_wa  = idx;
    w_wd  = '0;
    g_we  = 1'b0;
    g_wd  = '0;
    z1_we = 1'b0;
    z2_we = 1'b0;
    d2_we = 1'b0;
    z_wd  = '0;
    s      = '0;
    p      = '0;
    es_sum = '0;
    q50    = '0;
    q34    = '0;
    step   = '0;
    wdiff  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt  = in_action;
          x_nxt    = in_sample_x;
          y_nxt    = in_sample_y;
          ph_nxt   = 2'd0;
          k_nxt    = 2'd0;
          j_nxt    = 2'd0;
          ui_nxt   = '0;
          pred_nxt = '0;
          err_nxt  = '0;
          unique case (in_action)
            ACT_TRAIN, ACT_EVAL: state_nxt = S_BIAS;
            ACT_UPDATE:          state_nxt = S_UPD;
            default: begin
              // Load a single weight; an index past the last weight is ignored.
              w_wa      = in_weight_index;
              w_we      = (int'(in_weight_index) < NW);
              w_wd      = in_weight_value;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_BIAS: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          b_nxt     = sh[ACCW-1:0];
          ph_nxt    = 2'd0;
          k_nxt     = 2'd0;
          state_nxt = S_L1;
        end
      end
      S_L1: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          z_wd   = sat32(sum_t'(b_r) + sh);
          z1_we  = 1'b1;
          ph_nxt = 2'd0;
          if (k_r == 2'(H - 1)) begin
            k_nxt     = 2'd0;
            j_nxt     = 2'd0;
            state_nxt = S_L2;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      S_L2: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          s       = ((k_r == 2'd0) ? sum_t'(b_r) : acc_r) + sh;
          acc_nxt = s;
          ph_nxt  = 2'd0;
          if (k_r == 2'(H - 1)) begin
            z_wd  = sat32(s);
            z2_we = 1'b1;
            k_nxt = 2'd0;
            if (j_r == 2'(H - 1)) begin
              j_nxt     = 2'd0;
              state_nxt = S_L3;
            end else begin
              j_nxt = j_r + 2'd1;
            end
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      S_L3: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          s       = ((j_r == 2'd0) ? sum_t'(b_r) : acc_r) + sh;
          acc_nxt = s;
          ph_nxt  = 2'd0;
          if (j_r == 2'(H - 1)) begin
            p         = sat32(s);
            pred_nxt  = p;
            err_nxt   = sat32(sum_t'(p) - sum_t'(y_r));
            j_nxt     = 2'd0;
            state_nxt = (act_r == ACT_EVAL) ? S_EVAL : S_OUTG;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end
      end
      S_EVAL: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          // Half squared error, added with saturation.
          es_sum    = {1'b0, sqerr_r} + 48'(prod[62:F+1]);
          sqerr_nxt = es_sum[ESW] ? ERR_MAX : es_sum[ESW-1:0];
          ph_nxt    = 2'd0;
          state_nxt = S_DONE;
        end
      end
      S_OUTG: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else if (ph_r == 2'd1) begin
          g_we   = 1'b1;
          g_wd   = acc_add(g_rd, sh);
          ph_nxt = 2'd2;
        end else begin
          z_wd   = sat32(sh);
          d2_we  = 1'b1;
          ph_nxt = 2'd0;
          if (j_r == 2'(H - 1)) begin
            j_nxt     = 2'd0;
            k_nxt     = 2'd0;
            state_nxt = S_HID;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end
      end
      S_HID: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else if (ph_r == 2'd1) begin
          g_we   = 1'b1;
          g_wd   = acc_add(g_rd, sh);
          ph_nxt = 2'd2;
        end else begin
          s       = ((j_r == 2'd0) ? sum_t'(0) : acc_r) + sh;
          acc_nxt = s;
          ph_nxt  = 2'd0;
          if (j_r == 2'(H - 1)) begin
            d1_nxt    = sat32(s);
            state_nxt = S_FIRST;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end
      end
      S_FIRST: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          g_we   = 1'b1;
          g_wd   = acc_add(g_rd, sh);
          ph_nxt = 2'd0;
          j_nxt  = 2'd0;
          if (k_r == 2'(H - 1)) begin
            state_nxt = S_DONE;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_HID;
          end
        end
      end
      S_UPD: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else if (ph_r == 2'd1) begin
          lo_nxt = prod[63:0];
          ph_nxt = 2'd2;
        end else begin
          // Step is sum times rate over 2^32, floored, magnitude clamped.
          q50 = 50'(prod[48:0]) + 50'(lo_r[63:32])
              + 50'(g_rd[ACCW-1] && (lo_r[31:0] != 32'd0));
          q34 = (q50 > STEP_CLAMP) ? STEP_CLAMP[33:0] : q50[33:0];
          step  = g_rd[ACCW-1] ? -$signed({2'b00, q34}) : $signed({2'b00, q34});
          wdiff = 36'(w_rd) - step;
          w_we  = 1'b1;
          w_wd  = sat32(sum_t'(wdiff));
          g_we  = 1'b1;
          g_wd  = '0;
          ph_nxt = 2'd0;
          if (int'(ui_r) == NW - 1) begin
            sqerr_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            ui_nxt = ui_r + 4'd1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pred_nxt  = pred_r;
          out_err_nxt   = err_r;
          out_es_nxt    = sqerr_nxt;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= 2'd0;
      sqerr_r     <= '0;
      out_valid_r <= 1'b0;
      rate_r      <= 32'd8590;
      bias_r      <= 32'sd65536;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      sqerr_r     <= sqerr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index[1] == 1'b0)) begin
        if (cfg_index[0] == CFG_RATE) begin
          rate_r <= cfg_wdata;
        end else begin
          bias_r <= cfg_wdata;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    ui_r       <= ui_nxt;
    act_r      <= act_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    b_r        <= b_nxt;
    acc_r      <= acc_nxt;
    d1_r       <= d1_nxt;
    pred_r     <= pred_nxt;
    err_r      <= err_nxt;
    lo_r       <= lo_nxt;
    out_pred_r <= out_pred_nxt;
    out_err_r  <= out_err_nxt;
    out_es_r   <= out_es_nxt;
    if (z1_we) begin
      z1_r[k_r] <= z_wd;
    end
    if (z2_we) begin
      z2_r[j_r] <= z_wd;
    end
    if (d2_we) begin
      d2_r[j_r] <= z_wd;
    end
  end

  // Weights and gradient sums, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NW; i++) begin
        w_r[i] <= '0;
        g_r[i] <= '0;
      end
    end else begin
      if (w_we) begin
        w_r[w_wa] <= w_wd;
      end
      if (g_we) begin
        g_r[idx] <= g_wd;
      end
    end
  end

  // No item is taken while reset is held.
  assign in_stall       = (state_r != S_IDLE) || !rst_n;
  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;
  assign out_error      = out_err_r;
  assign out_error_sum  = out_es_r;

endmodule

### hw/rtl/tmbt_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// One registered 33x33 signed multiplier used by every step of the sequencer.
// ----------------------------------------------------------------------------
module tmbt_mul (
  input  logic              clk,
  input  tmbt_pkg::mul_req_t req,
  output tmbt_pkg::prod_t   prod
);
  import tmbt_pkg::*;

  prod_t prod_r;

  // Product is registered, so that the logic that uses it starts from a register.
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= req.a * req.b;
    end
  end

  assign prod = prod_r;

endmodule
